/* design/connection_cache_with_expiry_top_assert.svh */
// ----------------------------------------------------------------------------
// connection cache assertion macros
// shared property forms for the connection cache checks
// ----------------------------------------------------------------------------
`ifndef CONNECTION_CACHE_WITH_EXPIRY_TOP_ASSERT_SVH
`define CONNECTION_CACHE_WITH_EXPIRY_TOP_ASSERT_SVH

// same-cycle implication
`define CCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cce_pkg.sv */
// ----------------------------------------------------------------------------
// cce_pkg
// types and constants of the connection cache with expiry
// ----------------------------------------------------------------------------
`default_nettype none

package cce_pkg;

  localparam int unsigned SessionsDef = 32;
  localparam int unsigned KeepResetMs = 1000;

  localparam int unsigned NowW    = 48;
  localparam int unsigned IpW     = 32;
  localparam int unsigned PortW   = 16;
  localparam int unsigned UsumW   = 24;
  localparam int unsigned HandleW = 32;
  localparam int unsigned KeepW   = 32;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned HashW   = 25;
  localparam int unsigned HashCntW = 5;

  localparam int unsigned InDataW  = NowW + IpW + PortW + UsumW + HandleW;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_SWEEP  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    RES_RELEASED   = 3'd0,
    RES_HIT        = 3'd1,
    RES_MISS       = 3'd2,
    RES_ADDED      = 3'd3,
    RES_FULL       = 3'd4,
    RES_SWEEP_DONE = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_START,
    ST_HEAD,
    ST_EVAL,
    ST_MNEXT,
    ST_CLR,
    ST_HIT,
    ST_ADD,
    ST_SWNEXT,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

/* design/connection_cache_with_expiry_top.sv */
// ----------------------------------------------------------------------------
// connection_cache_with_expiry_top
// Cache of idle connections in hashed buckets, kept as linked lists in memory,
// with time-based expiry on every access and a sweep over all buckets.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add and lookup first reduce the 25-bit key
// sum modulo SESSIONS by a reciprocal multiply, then read the bucket list
// through the node memory: a lookup walks it one entry per cycle, an add
// checks only the head entry. From the first expired entry on, all entries
// are released, each result word held back while the output is stalled. A
// sweep visits every bucket in turn and ends with a final word.
// Entries and list links sit in synchronous memories with registered reads;
// bucket heads sit in a memory with a flop valid bit per bucket, so there is
// no clearing pass after reset. A write to keep_time_ms is taken at any time
// but only while the block is idle is its effect defined.
`default_nettype none

module connection_cache_with_expiry_top #(
  parameter int unsigned SESSIONS = cce_pkg::SessionsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cce_pkg::KeepW-1:0]     cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms, peer_ip, peer_port, user_byte_sum, conn_handle
  input  wire logic [cce_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // out_handle, bucket_index, total_entries, zero pad
  output logic [cce_pkg::OutDataW-1:0]       m_axis_tdata,
  // result_kind
  output logic [2:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned SW = $clog2(SESSIONS);
  localparam int unsigned NowW = cce_pkg::NowW;
  localparam int unsigned IpW = cce_pkg::IpW;
  localparam int unsigned PortW = cce_pkg::PortW;
  localparam int unsigned HW = cce_pkg::HandleW;
  localparam int unsigned OW = cce_pkg::IdxOutW;
  localparam int unsigned HashShift = cce_pkg::HashW + SW;
  localparam int unsigned ProdW = 2 * cce_pkg::HashW + 1;
  localparam longint unsigned HashMul =
    ((64'd1 << HashShift) + 64'(SESSIONS) - 64'd1) / 64'(SESSIONS);

  cce_pkg::state_e state_q, state_d, after_q, after_d;
  cce_pkg::req_e   req_q, req_d;
  cce_pkg::kind_e  fin_kind_q, fin_kind_d;

  logic [NowW-1:0]              now_q, now_d;
  logic [IpW-1:0]               ip_q, ip_d;
  logic [PortW-1:0]             port_q, port_d;
  logic [HW-1:0]                handle_q, handle_d;
  logic [cce_pkg::HashW-1:0]    sum_q, sum_d;
  logic [cce_pkg::HashCntW-1:0] cnt_q, cnt_d;
  logic [cce_pkg::HashW-1:0]    quot_q, quot_d, rem_full;
  logic [ProdW-1:0]             hash_prod;
  logic [SW-1:0]                bucket_q, bucket_d;
  logic [cce_pkg::KeepW-1:0]    keep_q;
  logic [SESSIONS-1:0]          valid_q, valid_d;
  logic [SESSIONS-1:0]          nonempty_q, nonempty_d;
  logic [OW-1:0]                live_q, live_d;
  logic [SW-1:0]                cur_q, cur_d, prev_q, prev_d, hit_slot_q, hit_slot_d;
  logic                         prev_head_q, prev_head_d;
  logic [SW:0]                  link_q, link_d;
  logic [HW-1:0]                hit_handle_q, hit_handle_d;

  // memories
  logic [IpW-1:0]   ip_mem     [SESSIONS];
  logic [PortW-1:0] port_mem   [SESSIONS];
  logic [HW-1:0]    handle_mem [SESSIONS];
  logic [NowW-1:0]  stamp_mem  [SESSIONS];
  logic [SW:0]      next_mem   [SESSIONS];
  logic [SW-1:0]    head_mem   [SESSIONS];

  logic [IpW-1:0]   rd_ip_q;
  logic [PortW-1:0] rd_port_q;
  logic [HW-1:0]    rd_handle_q;
  logic [NowW-1:0]  rd_stamp_q;
  logic [SW:0]      rd_next_q;
  logic [SW-1:0]    head_rd_q;

  logic             node_we, next_we, head_we;
  logic [SW-1:0]    next_waddr;
  logic [SW:0]      next_wdata;
  logic [SW-1:0]    head_wdata;

  logic             s_accept, out_free, expired, match, nx_has;
  logic [SW-1:0]    nx_idx;
  logic             free_found;
  logic [SW-1:0]    free_idx;
  logic [NowW:0]    limit;

  logic             emit, emit_last;
  cce_pkg::kind_e   emit_kind;
  logic [HW-1:0]    emit_handle;
  logic [SW-1:0]    emit_bucket;

  logic             m_valid_q;
  logic [cce_pkg::OutDataW-1:0] m_data_q;
  logic [2:0]       m_user_q;
  logic             m_last_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == cce_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign nx_has  = rd_next_q[SW];
  assign nx_idx  = rd_next_q[SW-1:0];
  assign limit   = {1'b0, rd_stamp_q} + {{(NowW + 1 - cce_pkg::KeepW){1'b0}}, keep_q};
  assign expired = ({1'b0, now_q} >= limit);
  assign match   = (rd_ip_q == ip_q) && (rd_port_q == port_q);

  // key sum modulo SESSIONS: quotient by reciprocal, then remainder
  assign hash_prod = ProdW'(sum_q) * ProdW'(HashMul);
  assign rem_full  = sum_q - quot_q * cce_pkg::HashW'(SESSIONS);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SESSIONS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cce_pkg::ST_IDLE: begin
        if (s_accept) begin
          priority case (cce_pkg::req_e'(s_axis_tuser))
            cce_pkg::REQ_NONE:  state_d = cce_pkg::ST_IDLE;
            cce_pkg::REQ_SWEEP: state_d = cce_pkg::ST_START;
            default:            state_d = cce_pkg::ST_HASH;
          endcase
        end
      end
      cce_pkg::ST_HASH: begin
        if (cnt_q == '0) state_d = cce_pkg::ST_START;
      end
      cce_pkg::ST_START: begin
        if (nonempty_q[bucket_q]) state_d = cce_pkg::ST_HEAD;
        else if (req_q == cce_pkg::REQ_ADD) state_d = cce_pkg::ST_ADD;
        else if (req_q == cce_pkg::REQ_LOOKUP) state_d = cce_pkg::ST_FIN;
        else state_d = cce_pkg::ST_SWNEXT;
      end
      cce_pkg::ST_HEAD: state_d = cce_pkg::ST_EVAL;
      cce_pkg::ST_EVAL: begin
        if (expired) state_d = cce_pkg::ST_CLR;
        else if (req_q == cce_pkg::REQ_LOOKUP) begin
          if (match) state_d = nx_has ? cce_pkg::ST_MNEXT : cce_pkg::ST_HIT;
          else state_d = nx_has ? cce_pkg::ST_EVAL : cce_pkg::ST_FIN;
        end else if (req_q == cce_pkg::REQ_ADD) state_d = cce_pkg::ST_ADD;
        else state_d = cce_pkg::ST_SWNEXT;
      end
      cce_pkg::ST_MNEXT: state_d = expired ? cce_pkg::ST_CLR : cce_pkg::ST_HIT;
      cce_pkg::ST_CLR: begin
        if (out_free && !nx_has) state_d = after_q;
      end
      cce_pkg::ST_HIT, cce_pkg::ST_ADD, cce_pkg::ST_FIN: begin
        if (out_free) state_d = cce_pkg::ST_IDLE;
      end
      cce_pkg::ST_SWNEXT: begin
        state_d = (bucket_q == SW'(SESSIONS - 1)) ? cce_pkg::ST_FIN : cce_pkg::ST_START;
      end
      default: state_d = cce_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    after_d      = after_q;
    req_d        = req_q;
    fin_kind_d   = fin_kind_q;
    now_d        = now_q;
    ip_d         = ip_q;
    port_d       = port_q;
    handle_d     = handle_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    quot_d       = quot_q;
    bucket_d     = bucket_q;
    valid_d      = valid_q;
    nonempty_d   = nonempty_q;
    live_d       = live_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_head_d  = prev_head_q;
    link_d       = link_q;
    hit_slot_d   = hit_slot_q;
    hit_handle_d = hit_handle_q;
    node_we      = 1'b0;
    next_we      = 1'b0;
    next_waddr   = prev_q;
    next_wdata   = '0;
    head_we      = 1'b0;
    head_wdata   = free_idx;
    emit         = 1'b0;
    emit_last    = 1'b0;
    emit_kind    = cce_pkg::RES_RELEASED;
    emit_handle  = '0;
    emit_bucket  = bucket_q;

    unique case (state_q)
      cce_pkg::ST_IDLE: begin
        if (s_accept) begin
          req_d    = cce_pkg::req_e'(s_axis_tuser);
          now_d    = s_axis_tdata[47:0];
          ip_d     = s_axis_tdata[79:48];
          port_d   = s_axis_tdata[95:80];
          handle_d = s_axis_tdata[151:120];
          sum_d    = cce_pkg::HashW'(s_axis_tdata[79:64]) + cce_pkg::HashW'(s_axis_tdata[63:48])
                   + cce_pkg::HashW'(s_axis_tdata[95:80])
                   + cce_pkg::HashW'(s_axis_tdata[119:96]);
          cnt_d    = cce_pkg::HashCntW'(1);
          bucket_d = '0;
          fin_kind_d = (cce_pkg::req_e'(s_axis_tuser) == cce_pkg::REQ_LOOKUP)
                     ? cce_pkg::RES_MISS : cce_pkg::RES_SWEEP_DONE;
        end
      end
      cce_pkg::ST_HASH: begin
        quot_d = cce_pkg::HashW'(hash_prod >> HashShift);
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) bucket_d = rem_full[SW-1:0];
      end
      cce_pkg::ST_START: ;
      cce_pkg::ST_HEAD: begin
        cur_d       = head_rd_q;
        prev_head_d = 1'b1;
      end
      cce_pkg::ST_EVAL: begin
        if (expired) begin
          // cut the list in front of the expired entry
          if (req_q == cce_pkg::REQ_ADD) after_d = cce_pkg::ST_ADD;
          else if (req_q == cce_pkg::REQ_LOOKUP) after_d = cce_pkg::ST_FIN;
          else after_d = cce_pkg::ST_SWNEXT;
          if (prev_head_q) nonempty_d[bucket_q] = 1'b0;
          else begin
            next_we    = 1'b1;
            next_waddr = prev_q;
            next_wdata = '0;
          end
        end else if (req_q == cce_pkg::REQ_LOOKUP) begin
          if (match) begin
            hit_slot_d   = cur_q;
            hit_handle_d = rd_handle_q;
            link_d       = rd_next_q;
            if (nx_has) cur_d = nx_idx;
          end else if (nx_has) begin
            prev_d      = cur_q;
            prev_head_d = 1'b0;
            cur_d       = nx_idx;
          end
        end
      end
      cce_pkg::ST_MNEXT: begin
        if (expired) begin
          after_d = cce_pkg::ST_HIT;
          link_d  = '0;
        end
      end
      cce_pkg::ST_CLR: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_kind      = cce_pkg::RES_RELEASED;
          emit_handle    = rd_handle_q;
          valid_d[cur_q] = 1'b0;
          live_d         = live_q - 1'b1;
          if (nx_has) cur_d = nx_idx;
        end
      end
      cce_pkg::ST_HIT: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_last           = 1'b1;
          emit_kind           = cce_pkg::RES_HIT;
          emit_handle         = hit_handle_q;
          valid_d[hit_slot_q] = 1'b0;
          live_d              = live_q - 1'b1;
          if (prev_head_q) begin
            if (link_q[SW]) begin
              head_we    = 1'b1;
              head_wdata = link_q[SW-1:0];
            end else nonempty_d[bucket_q] = 1'b0;
          end else begin
            next_we    = 1'b1;
            next_waddr = prev_q;
            next_wdata = link_q;
          end
        end
      end
      cce_pkg::ST_ADD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (free_found) begin
            emit_kind            = cce_pkg::RES_ADDED;
            node_we              = 1'b1;
            next_we              = 1'b1;
            next_waddr           = free_idx;
            next_wdata           = {nonempty_q[bucket_q], head_rd_q};
            head_we              = 1'b1;
            head_wdata           = free_idx;
            nonempty_d[bucket_q] = 1'b1;
            valid_d[free_idx]    = 1'b1;
            live_d               = live_q + 1'b1;
          end else emit_kind = cce_pkg::RES_FULL;
        end
      end
      cce_pkg::ST_SWNEXT: begin
        if (bucket_q != SW'(SESSIONS - 1)) bucket_d = bucket_q + 1'b1;
      end
      cce_pkg::ST_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_kind = fin_kind_q;
          if (fin_kind_q == cce_pkg::RES_SWEEP_DONE) emit_bucket = '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cce_pkg::ST_IDLE;
      keep_q     <= cce_pkg::KeepW'(cce_pkg::KeepResetMs);
      valid_q    <= '0;
      nonempty_q <= '0;
      live_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      nonempty_q <= nonempty_d;
      live_q     <= live_d;
      if (cfg_valid_i) keep_q <= cfg_data_i;
      if (emit) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    after_q      <= after_d;
    req_q        <= req_d;
    fin_kind_q   <= fin_kind_d;
    now_q        <= now_d;
    ip_q         <= ip_d;
    port_q       <= port_d;
    handle_q     <= handle_d;
    sum_q        <= sum_d;
    cnt_q        <= cnt_d;
    quot_q       <= quot_d;
    bucket_q     <= bucket_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_head_q  <= prev_head_d;
    link_q       <= link_d;
    hit_slot_q   <= hit_slot_d;
    hit_handle_q <= hit_handle_d;
    if (emit) begin
      m_data_q <= {{(cce_pkg::OutDataW - HW - 2 * OW){1'b0}}, live_d,
                   OW'(emit_bucket), emit_handle};
      m_user_q <= emit_kind;
      m_last_q <= emit_last;
    end
  end

  // entry and link memories
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      ip_mem[free_idx]     <= ip_q;
      port_mem[free_idx]   <= port_q;
      handle_mem[free_idx] <= handle_q;
      stamp_mem[free_idx]  <= now_q;
    end
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (head_we) head_mem[bucket_q] <= head_wdata;
    rd_ip_q     <= ip_mem[cur_d];
    rd_port_q   <= port_mem[cur_d];
    rd_handle_q <= handle_mem[cur_d];
    rd_stamp_q  <= stamp_mem[cur_d];
    rd_next_q   <= next_mem[cur_d];
    head_rd_q   <= head_mem[bucket_q];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

`include "connection_cache_with_expiry_top_assert.svh"

  `CCE_ASSERT_IMP(a_live_count, 1'b1, $countones(valid_q) == live_q, "live count mismatch")
  `CCE_ASSERT_IMP(a_bucket_live, |nonempty_q, live_q != '0, "nonempty bucket with no entries")
  `CCE_ASSERT_NXT(a_last_idle, emit && emit_last, state_q == cce_pkg::ST_IDLE,
                  "not idle after final word")
  `CCE_ASSERT_IMP(a_emit_room, emit, out_free, "word emitted into a full output")

endmodule

`default_nettype wire
